>>> sv/bcd_pkg.sv
// shared types and codes for the bipartite check block
`timescale 1ns / 1ps

package bcd_pkg;

    localparam int FUNC_W    = 2;
    localparam int FIELD_W   = 4;
    localparam int VERDICT_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD      = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHECK    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

    localparam logic [VERDICT_W-1:0] VERDICT_ACK           = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BIPARTITE     = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_NOT_BIPARTITE = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_UNUSED        = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD_SRC,
        S_ADD_WR_SRC,
        S_ADD_RD_DST,
        S_ADD_WR_DST,
        S_CHK_LOAD,
        S_CHK_SCAN,
        S_CHK_POP,
        S_EMIT
    } state_t;

endpackage

>>> sv/bcd_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module bcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bipartite_check_dfs.sv
// add item: reads and rewrites the source row, then the destination row, in S_ADD_RD_SRC,
//   S_ADD_WR_SRC, S_ADD_RD_DST and S_ADD_WR_DST, then S_EMIT; clear, reserved, an edge or
//   a start out of range go straight to S_EMIT; no overlap with the next item
// check item: S_CHK_LOAD per reached vertex and per resume after a pop (via S_CHK_POP), then
//   one adjacency bit tested per cycle in S_CHK_SCAN; this single-bit scan sets the check's length
// a new item is taken whenever the sequencer is idle, even while a result waits
// aresetn (synchronous) empties the graph at once through per-row valid bits, no sweep
`timescale 1ns / 1ps

module bipartite_check_dfs #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // edge_src[3:0], edge_dest[7:4], start_vertex[11:8], zero
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // verdict[1:0], zero
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int UW = $clog2(MAX_VERTICES + 1);
    localparam int LW = UW;
    localparam int SW = VW + UW;
    localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    bcd_pkg::state_t state_reg, state_next;

    logic [bcd_pkg::FIELD_W-1:0] src_reg, src_next;
    logic [bcd_pkg::FIELD_W-1:0] dst_reg, dst_next;
    logic [VW-1:0]               top_v_reg, top_v_next;
    logic [UW-1:0]               top_u_reg, top_u_next;
    logic [LW-1:0]               level_reg, level_next;
    logic [MAX_VERTICES-1:0]     visited_reg, visited_next;
    logic [MAX_VERTICES-1:0]     side_reg, side_next;
    logic [MAX_VERTICES-1:0]     row_reg, row_next;
    logic [MAX_VERTICES-1:0]     row_valid_reg, row_valid_next;
    logic [bcd_pkg::VERDICT_W-1:0] res_reg, res_next;
    logic                          m_valid_reg, m_valid_next;
    logic [bcd_pkg::VERDICT_W-1:0] m_verdict_reg, m_verdict_next;

    logic                        adj_we;
    logic [VW-1:0]               adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0]     adj_wdata, adj_rdata;
    logic                        stk_we;
    logic [VW-1:0]               stk_waddr, stk_raddr;
    logic [SW-1:0]               stk_wdata, stk_rdata;

    logic                        in_accept;
    logic [bcd_pkg::FIELD_W-1:0] in_src, in_dst, in_start;
    logic                        in_edge_ok, in_start_ok;
    logic [VW-1:0]               src_idx, dst_idx, u_idx;
    logic [LW-1:0]               lvl_m1, lvl_m2;
    logic                        scan_done, edge_hit, u_seen, side_v, side_u, can_push;
    logic                        slot_free;

    assign in_accept   = s_tvalid && s_tready;
    assign in_src      = s_tdata[3:0];
    assign in_dst      = s_tdata[7:4];
    assign in_start    = s_tdata[11:8];
    assign in_edge_ok  = (32'(in_src) < 32'(MAX_VERTICES)) && (32'(in_dst) < 32'(MAX_VERTICES));
    assign in_start_ok = 32'(in_start) < 32'(MAX_VERTICES);

    assign src_idx   = VW'(src_reg);
    assign dst_idx   = VW'(dst_reg);
    assign u_idx     = top_u_reg[VW-1:0];
    assign lvl_m1    = level_reg - LW'(1);
    assign lvl_m2    = level_reg - LW'(2);
    assign scan_done = top_u_reg == UW'(MAX_VERTICES);
    assign edge_hit  = row_reg[u_idx];
    assign u_seen    = visited_reg[u_idx];
    assign side_v    = side_reg[top_v_reg];
    assign side_u    = side_reg[u_idx];
    assign can_push  = level_reg < LW'(MAX_VERTICES);
    assign slot_free = !m_valid_reg || m_tready;

    assign s_tready = state_reg == bcd_pkg::S_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - bcd_pkg::VERDICT_W){1'b0}}, m_verdict_reg};

    bcd_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (aclk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // stack frames below the top one: {vertex, next neighbor to scan}
    bcd_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .clk   (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bcd_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (s_tuser)
                        bcd_pkg::FUNC_ADD:   state_next = in_edge_ok ? bcd_pkg::S_ADD_RD_SRC
                                                                     : bcd_pkg::S_EMIT;
                        bcd_pkg::FUNC_CHECK: state_next = in_start_ok ? bcd_pkg::S_CHK_LOAD
                                                                      : bcd_pkg::S_EMIT;
                        default:             state_next = bcd_pkg::S_EMIT;
                    endcase
                end
            end
            bcd_pkg::S_ADD_RD_SRC: state_next = bcd_pkg::S_ADD_WR_SRC;
            bcd_pkg::S_ADD_WR_SRC: state_next = bcd_pkg::S_ADD_RD_DST;
            bcd_pkg::S_ADD_RD_DST: state_next = bcd_pkg::S_ADD_WR_DST;
            bcd_pkg::S_ADD_WR_DST: state_next = bcd_pkg::S_EMIT;
            bcd_pkg::S_CHK_LOAD:   state_next = bcd_pkg::S_CHK_SCAN;
            bcd_pkg::S_CHK_SCAN: begin
                if (scan_done) begin
                    state_next = (level_reg == LW'(1)) ? bcd_pkg::S_EMIT : bcd_pkg::S_CHK_POP;
                end else if (edge_hit) begin
                    if (!u_seen) begin
                        state_next = can_push ? bcd_pkg::S_CHK_LOAD : bcd_pkg::S_CHK_SCAN;
                    end else if (side_u == side_v) begin
                        state_next = bcd_pkg::S_EMIT;
                    end
                end
            end
            bcd_pkg::S_CHK_POP: state_next = bcd_pkg::S_CHK_LOAD;
            bcd_pkg::S_EMIT: begin
                if (slot_free) begin
                    state_next = bcd_pkg::S_IDLE;
                end
            end
            default: state_next = bcd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        src_next       = src_reg;
        dst_next       = dst_reg;
        top_v_next     = top_v_reg;
        top_u_next     = top_u_reg;
        level_next     = level_reg;
        visited_next   = visited_reg;
        side_next      = side_reg;
        row_next       = row_reg;
        row_valid_next = row_valid_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_verdict_next = m_verdict_reg;
        adj_we         = 1'b0;
        adj_waddr      = '0;
        adj_wdata      = '0;
        adj_raddr      = top_v_reg;
        stk_we         = 1'b0;
        stk_waddr      = '0;
        stk_wdata      = '0;
        stk_raddr      = '0;
        case (state_reg)
            bcd_pkg::S_IDLE: begin
                if (in_accept) begin
                    src_next   = in_src;
                    dst_next   = in_dst;
                    top_v_next = VW'(in_start);
                    top_u_next = '0;
                    adj_raddr  = VW'(in_start);
                    res_next   = bcd_pkg::VERDICT_ACK;
                    case (s_tuser)
                        bcd_pkg::FUNC_CLEAR: row_valid_next = '0;
                        bcd_pkg::FUNC_CHECK: begin
                            visited_next = '0;
                            side_next    = '0;
                            level_next   = '0;
                            res_next     = bcd_pkg::VERDICT_BIPARTITE;
                            if (in_start_ok) begin
                                visited_next = ROW_ONE << VW'(in_start);
                                level_next   = LW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bcd_pkg::S_ADD_RD_SRC: adj_raddr = src_idx;
            bcd_pkg::S_ADD_WR_SRC: begin
                adj_we    = 1'b1;
                adj_waddr = src_idx;
                adj_wdata = (row_valid_reg[src_idx] ? adj_rdata : '0) | (ROW_ONE << dst_idx);
                row_valid_next[src_idx] = 1'b1;
            end
            bcd_pkg::S_ADD_RD_DST: adj_raddr = dst_idx;
            bcd_pkg::S_ADD_WR_DST: begin
                adj_we    = 1'b1;
                adj_waddr = dst_idx;
                adj_wdata = (row_valid_reg[dst_idx] ? adj_rdata : '0) | (ROW_ONE << src_idx);
                row_valid_next[dst_idx] = 1'b1;
            end
            bcd_pkg::S_CHK_LOAD: begin
                row_next = row_valid_reg[top_v_reg] ? adj_rdata : '0;
            end
            bcd_pkg::S_CHK_SCAN: begin
                if (scan_done) begin
                    // pop: fetch the frame below, it becomes the new top
                    level_next = lvl_m1;
                    stk_raddr  = lvl_m2[VW-1:0];
                    res_next   = bcd_pkg::VERDICT_BIPARTITE;
                end else begin
                    top_u_next = top_u_reg + UW'(1);
                    if (edge_hit) begin
                        if (!u_seen) begin
                            visited_next[u_idx] = 1'b1;
                            side_next[u_idx]    = !side_v;
                            if (can_push) begin
                                stk_we     = 1'b1;
                                stk_waddr  = lvl_m1[VW-1:0];
                                stk_wdata  = {top_v_reg, top_u_reg + UW'(1)};
                                top_v_next = u_idx;
                                top_u_next = '0;
                                level_next = level_reg + LW'(1);
                                adj_raddr  = u_idx;
                            end
                        end else if (side_u == side_v) begin
                            res_next   = bcd_pkg::VERDICT_NOT_BIPARTITE;
                            level_next = '0;
                        end
                    end
                end
            end
            bcd_pkg::S_CHK_POP: begin
                top_v_next = stk_rdata[SW-1:UW];
                top_u_next = stk_rdata[UW-1:0];
                adj_raddr  = stk_rdata[SW-1:UW];
            end
            bcd_pkg::S_EMIT: begin
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    m_verdict_next = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bcd_pkg::S_IDLE;
            level_reg     <= '0;
            visited_reg   <= '0;
            side_reg      <= '0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            visited_reg   <= visited_next;
            side_reg      <= side_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        top_v_reg     <= top_v_next;
        top_u_reg     <= top_u_next;
        row_reg       <= row_next;
        res_reg       <= res_next;
        m_verdict_reg <= m_verdict_next;
    end

endmodule

>>> sv/bcd_checker.sv
// port-level assertions for the bipartite check block, bound to the top level
`timescale 1ns / 1ps

module bcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // verdict code three is never produced, upper bits stay zero
    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != bcd_pkg::VERDICT_UNUSED) && (m_tdata[7:2] == 6'd0))
        else $error("illegal verdict on result channel");

    // one item at a time: the sequencer leaves idle right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accept");

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind bipartite_check_dfs bcd_checker u_bcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
